@@ sv/tcq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal colour quantizer package
// Shared types, codes and tables of the colour quantizer pipeline.
// ----------------------------------------------------------------------------
package tcq_pkg;

	localparam logic [1:0] KIND_KEEP    = 2'd0;
	localparam logic [1:0] KIND_DEFAULT = 2'd1;
	localparam logic [1:0] KIND_INDEX   = 2'd2;
	localparam logic [1:0] KIND_RGB     = 2'd3;

	localparam logic [2:0] CAP_NONE  = 3'd0;
	localparam logic [2:0] CAP_EIGHT = 3'd1;
	localparam logic [2:0] CAP_16    = 3'd2;
	localparam logic [2:0] CAP_256   = 3'd3;
	localparam logic [2:0] CAP_TRUE  = 3'd4;

	localparam logic [0:0] REG_CAPABILITY = 1'd0;
	localparam logic [0:0] REG_OPTIMIZE   = 1'd1;

	typedef struct packed {
		logic [1:0] color_kind;
		logic [7:0] palette_index;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} req_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} res_t;

	function automatic logic [7:0] cube_level(input logic [2:0] i);
		unique case (i)
			3'd0: cube_level = 8'h00;
			3'd1: cube_level = 8'h5f;
			3'd2: cube_level = 8'h87;
			3'd3: cube_level = 8'haf;
			3'd4: cube_level = 8'hd7;
			default: cube_level = 8'hff;
		endcase
	endfunction

	// Level index of one component: (t - 35) / 40 with t = c + 28 below 75.
	function automatic logic [2:0] level_of(input logic [7:0] c);
		logic [8:0] t;
		t = (c < 8'd75) ? ({1'b0, c} + 9'd28) : {1'b0, c};
		if (t < 9'd75)       level_of = 3'd0;
		else if (t < 9'd115) level_of = 3'd1;
		else if (t < 9'd155) level_of = 3'd2;
		else if (t < 9'd195) level_of = 3'd3;
		else if (t < 9'd235) level_of = 3'd4;
		else                 level_of = 3'd5;
	endfunction

	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		sq_diff = {8'd0, d} * {8'd0, d};
	endfunction

	localparam logic [3:0] TO_SIXTEEN [256] = '{
		0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
		0,4,4,4,12,12,2,6,4,4,12,12,2,2,6,4,
		12,12,2,2,2,6,12,12,10,10,10,14,14,12,10,10,
		10,10,14,14,1,5,5,5,5,12,3,8,4,4,12,12,
		2,2,6,4,12,12,2,2,2,6,12,12,10,10,10,10,
		14,12,10,10,10,10,10,14,1,5,5,5,5,5,3,1,
		5,5,5,5,3,3,8,4,12,12,2,2,2,6,12,12,
		10,10,10,10,14,12,10,10,10,10,10,14,1,1,5,5,
		5,5,1,1,1,5,13,13,3,3,1,5,13,13,3,3,
		3,7,12,12,10,10,10,10,14,12,10,10,10,10,10,14,
		9,9,9,5,13,13,9,9,13,13,13,13,9,9,9,9,
		13,13,3,3,3,13,13,13,11,11,11,11,7,12,11,10,
		10,10,10,14,9,9,9,13,13,13,9,9,9,9,9,13,
		9,9,9,13,13,13,3,3,3,9,13,13,3,3,11,11,
		9,13,11,11,11,11,11,15,0,0,0,0,0,0,8,8,
		8,8,8,8,7,7,7,7,7,7,15,15,15,15,15,15
	};

endpackage

@@ sv/terminal_color_quantizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal colour quantizer
// Maps keep, default, palette and RGB colours to the terminal's colour depth.
// The match stages and the result register lie between start and the done strobe.
// Throughput: one request per cycle; busy is always low.
// Results cannot be held off; each stays one cycle, marked by done.
// Reset: capability 256 colours, exact match off, pipeline empty.
// ----------------------------------------------------------------------------
module terminal_color_quantizer import tcq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       done,
	output res_t       result,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [2:0] cfg_data
);

	logic [2:0] capability_q;
	logic       optimize_q;
	logic       valid_s3;
	req_t       req_s3;
	logic [7:0] pal_s3;
	logic       hit_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capability_q <= CAP_256;
			optimize_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAPABILITY: capability_q <= cfg_data;
				REG_OPTIMIZE:   optimize_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tcq_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start && !busy),
		.req      (req),
		.valid_s3 (valid_s3),
		.req_s3   (req_s3),
		.pal_s3   (pal_s3),
		.hit_s3   (hit_s3)
	);

	tcq_reduce u_reduce (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid          (valid_s3),
		.req            (req_s3),
		.pal_in         (pal_s3),
		.hit            (hit_s3),
		.capability     (capability_q),
		.exact_optimize (optimize_q),
		.done           (done),
		.result         (result)
	);

endmodule

@@ sv/tcq_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour quantizer nearest-match stages
// Finds cube levels and gray step, then squared distances, then the nearest
// 256-colour entry; three register stages.
// ----------------------------------------------------------------------------
module tcq_match import tcq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  req_t       req,
	output logic       valid_s3,
	output req_t       req_s3,
	output logic [7:0] pal_s3,
	output logic       hit_s3
);

	logic        valid_s1, valid_s2;
	req_t        req_s1, req_s2;
	logic [2:0]  ri_s1, gi_s1, bi_s1, ri_s2, gi_s2, bi_s2;
	logic [4:0]  gidx_s1, gidx_s2;
	logic [17:0] cube_d_s2, gray_d_s2;
	logic [9:0]  sum;
	logic [9:0]  avg;
	logic [4:0]  gidx;
	logic [7:0]  gv;
	logic [7:0]  cube_idx;

	assign sum = 10'(req.red_in) + 10'(req.green_in) + 10'(req.blue_in);
	// Division by three as a reciprocal multiply; exact for sums up to 765.
	assign avg = 10'((20'(sum) * 20'd683) >> 11);

	always_comb begin
		if (avg > 10'd238)   gidx = 5'd23;
		else if (avg < 10'd3) gidx = 5'd0;
		else                  gidx = 5'((20'(avg - 10'd3) * 20'd205) >> 11);
	end

	assign gv = 8'd8 + 8'(10 * gidx_s1);
	assign cube_idx = 8'd16 + ({5'd0, ri_s2} * 8'd36) + ({5'd0, gi_s2} * 8'd6)
		+ {5'd0, bi_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		req_s1  <= req;
		ri_s1   <= level_of(req.red_in);
		gi_s1   <= level_of(req.green_in);
		bi_s1   <= level_of(req.blue_in);
		gidx_s1 <= gidx;

		req_s2    <= req_s1;
		ri_s2     <= ri_s1;
		gi_s2     <= gi_s1;
		bi_s2     <= bi_s1;
		gidx_s2   <= gidx_s1;
		cube_d_s2 <= 18'(sq_diff(cube_level(ri_s1), req_s1.red_in))
			+ 18'(sq_diff(cube_level(gi_s1), req_s1.green_in))
			+ 18'(sq_diff(cube_level(bi_s1), req_s1.blue_in));
		gray_d_s2 <= 18'(sq_diff(gv, req_s1.red_in))
			+ 18'(sq_diff(gv, req_s1.green_in))
			+ 18'(sq_diff(gv, req_s1.blue_in));

		req_s3 <= req_s2;
		if (gray_d_s2 < cube_d_s2) begin
			pal_s3 <= 8'd232 + 8'(gidx_s2);
			hit_s3 <= (gray_d_s2 == 18'd0);
		end else begin
			pal_s3 <= cube_idx;
			hit_s3 <= (cube_d_s2 == 18'd0);
		end
	end

endmodule

@@ sv/tcq_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour quantizer capability stage
// Reduces the palette result to the configured terminal capability.
// ----------------------------------------------------------------------------
module tcq_reduce import tcq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  req_t       req,
	input  logic [7:0] pal_in,
	input  logic       hit,
	input  logic [2:0] capability,
	input  logic       exact_optimize,
	output logic       done,
	output res_t       result
);

	logic [7:0] pal;
	logic [3:0] six;
	res_t       res;

	assign pal = (req.color_kind == KIND_INDEX) ? req.palette_index : pal_in;
	assign six = TO_SIXTEEN[pal];

	always_comb begin
		res = '0;
		res.out_kind = req.color_kind;
		if (req.color_kind == KIND_INDEX || req.color_kind == KIND_RGB) begin
			res.out_kind = KIND_INDEX;
			unique case (capability)
				CAP_EIGHT: res.out_index = {5'd0, six[2:0]};
				CAP_16:    res.out_index = {4'd0, six};
				CAP_256:   res.out_index = pal;
				CAP_TRUE: begin
					if (req.color_kind == KIND_RGB && !(exact_optimize && hit)) begin
						res.out_kind  = KIND_RGB;
						res.out_red   = req.red_in;
						res.out_green = req.green_in;
						res.out_blue  = req.blue_in;
					end else begin
						res.out_index = pal;
					end
				end
				default: res.out_kind = KIND_DEFAULT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

endmodule
